>>> hw/rtl/ttab_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory table package
// Shared widths, command and status codes for the trajectory table.
// ----------------------------------------------------------------------------
package ttab_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned NUM_VALS      = 6;
    localparam int unsigned ROW_W         = DATA_W * (NUM_VALS + 1);
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned STATUS_W      = 3;
    localparam int unsigned DEF_MAX_ROWS  = 256;
    localparam int unsigned DEF_FRAC_BITS = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP    = 3'd0,
        ST_CLAMP_LO  = 3'd1,
        ST_CLAMP_HI  = 3'd2,
        ST_NO_BRKT   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

endpackage

>>> hw/rtl/ttab_row_mem.sv
// ----------------------------------------------------------------------------
// Trajectory table row store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ttab_row_mem #(
    parameter int unsigned MAX_ROWS = ttab_pkg::DEF_MAX_ROWS,
    localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [ttab_pkg::ROW_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [ttab_pkg::ROW_W-1:0] rd_data
);

    logic [ttab_pkg::ROW_W-1:0] mem [MAX_ROWS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/ttab_div.sv
// ----------------------------------------------------------------------------
// Trajectory table ratio divider
// Restoring divider giving (num << FRAC_BITS) / den for num <= den, one bit a cycle.
// ----------------------------------------------------------------------------
module ttab_div #(
    parameter int unsigned FRAC_BITS = ttab_pkg::DEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [32:0]          num,
    input  logic [32:0]          den,
    output logic                 done,
    output logic [FRAC_BITS:0]   quot
);

    localparam int unsigned CW = $clog2(FRAC_BITS + 1);

    logic [33:0]        rem_reg, rem_next;
    logic [32:0]        den_reg;
    logic [FRAC_BITS:0] q_reg, q_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               bit_ge;
    logic [33:0]        rem_sub;

    assign bit_ge  = rem_reg >= {1'b0, den_reg};
    assign rem_sub = bit_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = {1'b0, num};
            q_next   = '0;
            cnt_next = CW'(FRAC_BITS);
            if (den == '0) begin
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            q_next   = {q_reg[FRAC_BITS-1:0], bit_ge};
            rem_next = {rem_sub[32:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> hw/rtl/trajectory_table_interpolator.sv
// ----------------------------------------------------------------------------
// Trajectory table interpolator
// Row table in one memory; clamped piecewise linear lookup of six values.
// ----------------------------------------------------------------------------
// Append and clear give no result word.
// A query makes one memory read a cycle while scanning for a bracket, takes
// one quotient bit a cycle, then one multiply and one add per value through a
// single shared multiplier.
// Reset empties the table and zeroes the last returned state; no memory sweep.
module trajectory_table_interpolator #(
    parameter int unsigned MAX_ROWS  = ttab_pkg::DEF_MAX_ROWS,
    parameter int unsigned FRAC_BITS = ttab_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sample_time, in_value_0 .. in_value_5
    input  logic [ttab_pkg::ROW_W-1:0]    s_tdata,
    // command
    input  logic [ttab_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_time, out_value_0 .. out_value_5
    output logic [ttab_pkg::ROW_W-1:0]    m_tdata,
    // status
    output logic [ttab_pkg::STATUS_W-1:0] m_tuser
);

    localparam int unsigned AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CNW = $clog2(MAX_ROWS + 1);
    localparam int unsigned DW  = ttab_pkg::DATA_W;
    localparam int unsigned PW  = 35 + FRAC_BITS;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CHK0 = 9'b000000010,
        S_CHKL = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_ADD  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_HOLD = 9'b100000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNW-1:0]              count_reg, count_next;
    logic signed [DW-1:0]        qtime_reg;
    logic [ttab_pkg::ROW_W-1:0]  last_reg, last_next;
    logic [ttab_pkg::ROW_W-1:0]  row_a_reg, row_b_reg;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [2:0]                  vsel_reg, vsel_next;
    logic [ttab_pkg::STATUS_W-1:0] stat_reg, stat_next;
    logic signed [PW-1:0]        prod_reg;
    logic                        m_valid_reg;
    logic [ttab_pkg::ROW_W-1:0]  m_data_reg;
    logic [ttab_pkg::STATUS_W-1:0] m_user_reg;

    logic                        s_acc;
    logic                        wr_en;
    logic [AW-1:0]               rd_addr;
    logic [ttab_pkg::ROW_W-1:0]  rd_data;
    logic signed [DW-1:0]        rd_time, a_time;
    logic                        found;
    logic                        div_start, div_done;
    logic [32:0]                 div_num, div_den;
    logic [FRAC_BITS:0]          ratio;
    logic signed [DW-1:0]        va, vb;
    logic signed [32:0]          vdiff;
    logic signed [PW-1:0]        prod_shift;
    logic [AW-1:0]               last_idx;
    logic                        out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign wr_en    = s_acc && (s_tuser == ttab_pkg::CMD_APPEND) &&
                      (count_reg < CNW'(MAX_ROWS));
    assign rd_time  = rd_data[DW-1:0];
    assign a_time   = row_a_reg[DW-1:0];
    assign last_idx = AW'(count_reg - 1'b1);
    assign found    = (state_reg == S_SCAN) && (idx_reg != '0) &&
                      (a_time <= qtime_reg) && (rd_time >= qtime_reg);
    assign div_start = found;
    assign div_num  = 33'({qtime_reg[DW-1], qtime_reg} - {a_time[DW-1], a_time});
    assign div_den  = 33'({rd_time[DW-1], rd_time} - {a_time[DW-1], a_time});
    assign va       = row_a_reg[DW*(vsel_reg+1) +: DW];
    assign vb       = row_b_reg[DW*(vsel_reg+1) +: DW];
    assign vdiff    = {vb[DW-1], vb} - {va[DW-1], va};
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign out_free = !m_valid_reg || m_tready;

    ttab_row_mem #(.MAX_ROWS(MAX_ROWS)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ttab_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (ratio)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        vsel_next  = vsel_reg;
        stat_next  = stat_reg;
        rd_addr    = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        ttab_pkg::CMD_APPEND: begin
                            if (wr_en) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ttab_pkg::CMD_CLEAR: count_next = '0;
                        ttab_pkg::CMD_QUERY: begin
                            if (count_reg == '0) begin
                                stat_next  = ttab_pkg::ST_EMPTY;
                                state_next = S_FIN;
                            end else begin
                                state_next = S_CHK0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CHK0: begin
                if (qtime_reg <= rd_time) begin
                    last_next  = rd_data;
                    stat_next  = ttab_pkg::ST_CLAMP_LO;
                    state_next = S_FIN;
                end else begin
                    rd_addr    = last_idx;
                    state_next = S_CHKL;
                end
            end
            S_CHKL: begin
                if (qtime_reg >= rd_time) begin
                    last_next  = rd_data;
                    stat_next  = ttab_pkg::ST_CLAMP_HI;
                    state_next = S_FIN;
                end else begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_addr = idx_reg + 1'b1;
                if (found) begin
                    state_next = S_DIV;
                end else if (idx_reg == last_idx) begin
                    stat_next  = ttab_pkg::ST_NO_BRKT;
                    state_next = S_FIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV: begin
                vsel_next = '0;
                if (div_done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_ADD;
            S_ADD: begin
                last_next[DW*(vsel_reg+1) +: DW] = va + prod_shift[DW-1:0];
                if (vsel_reg == 3'(ttab_pkg::NUM_VALS - 1)) begin
                    last_next[DW-1:0] = qtime_reg;
                    stat_next  = ttab_pkg::ST_INTERP;
                    state_next = S_FIN;
                end else begin
                    vsel_next  = vsel_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FIN: state_next = out_free ? S_IDLE : S_HOLD;
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            if ((state_reg == S_FIN || state_reg == S_HOLD) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        idx_reg  <= idx_next;
        vsel_reg <= vsel_next;
        stat_reg <= stat_next;
        if (s_acc) begin
            qtime_reg <= s_tdata[DW-1:0];
        end
        if (state_reg == S_SCAN) begin
            if (found) begin
                row_b_reg <= rd_data;
            end else begin
                row_a_reg <= rd_data;
            end
        end
        if (state_reg == S_MUL) begin
            prod_reg <= PW'(vdiff) * PW'($signed({1'b0, ratio}));
        end
        if ((state_reg == S_FIN || state_reg == S_HOLD) && out_free) begin
            m_data_reg <= last_reg;
            m_user_reg <= stat_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNW'(MAX_ROWS))
        else $error("row count beyond table depth");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN || state_reg == S_HOLD))
        else $error("result word raised outside finish");

    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide phase");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == ttab_pkg::CMD_QUERY) |=> state_reg != S_IDLE)
        else $error("query dropped");

endmodule

>>> bench/tb_trajectory_table_interpolator.sv
// ----------------------------------------------------------------------------
// Trajectory table interpolator testbench
// Appends, clears and queries rows; predicts each query result (clamp ends,
// bracketing interpolation, empty and unbracketed repeats) and checks words.
// ----------------------------------------------------------------------------
module tb_trajectory_table_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ttab_pkg::ROW_W-1:0]    row;
        logic [ttab_pkg::STATUS_W-1:0] status;
    } lookup_t;

    class lookup_board;
        logic signed [31:0] tab_t [ttab_pkg::DEF_MAX_ROWS];
        logic signed [31:0] tab_v [ttab_pkg::DEF_MAX_ROWS][ttab_pkg::NUM_VALS];
        int unsigned        rows;
        logic signed [31:0] held_t;
        logic signed [31:0] held_v [ttab_pkg::NUM_VALS];
        lookup_t            pending [$];
        int                 errors;

        function new();
            rows = 0;
            held_t = 0;
            foreach (held_v[j]) held_v[j] = 0;
            errors = 0;
        endfunction

        function void keep_row(int unsigned r);
            held_t = tab_t[r];
            foreach (held_v[j]) held_v[j] = tab_v[r][j];
        endfunction

        function void push(ttab_pkg::status_t st);
            lookup_t e;
            e.row[31:0] = held_t;
            for (int j = 0; j < ttab_pkg::NUM_VALS; j++) e.row[32*(j+1) +: 32] = held_v[j];
            e.status = st;
            pending.push_back(e);
        endfunction

        function void note_word(ttab_pkg::cmd_t cmd, logic [ttab_pkg::ROW_W-1:0] d);
            logic signed [31:0] t;
            logic signed [63:0] a, b, num, den, ratio, p;
            bit found;
            t = d[31:0];
            found = 0;
            case (cmd)
                ttab_pkg::CMD_APPEND: begin
                    if (rows < ttab_pkg::DEF_MAX_ROWS) begin
                        tab_t[rows] = t;
                        for (int j = 0; j < ttab_pkg::NUM_VALS; j++)
                            tab_v[rows][j] = d[32*(j+1) +: 32];
                        rows++;
                    end
                end
                ttab_pkg::CMD_CLEAR: rows = 0;
                ttab_pkg::CMD_QUERY: begin
                    if (rows == 0) push(ttab_pkg::ST_EMPTY);
                    else if (t <= tab_t[0]) begin
                        keep_row(0);
                        push(ttab_pkg::ST_CLAMP_LO);
                    end else if (t >= tab_t[rows-1]) begin
                        keep_row(rows - 1);
                        push(ttab_pkg::ST_CLAMP_HI);
                    end else begin
                        for (int i = 0; i + 1 < rows && !found; i++) begin
                            if (tab_t[i] <= t && tab_t[i+1] >= t) begin
                                found = 1;
                                den = 64'(tab_t[i+1]) - 64'(tab_t[i]);
                                num = 64'(t) - 64'(tab_t[i]);
                                ratio = (den > 0) ?
                                        (num <<< ttab_pkg::DEF_FRAC_BITS) / den : 0;
                                held_t = t;
                                for (int j = 0; j < ttab_pkg::NUM_VALS; j++) begin
                                    a = tab_v[i][j];
                                    b = tab_v[i+1][j];
                                    p = (b - a) * ratio;
                                    held_v[j] = 32'(a + (p >>> ttab_pkg::DEF_FRAC_BITS));
                                end
                                push(ttab_pkg::ST_INTERP);
                            end
                        end
                        if (!found) push(ttab_pkg::ST_NO_BRKT);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [ttab_pkg::ROW_W-1:0] d,
                                 logic [ttab_pkg::STATUS_W-1:0] st);
            lookup_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h status %0d", $time, d, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int f = 0; f <= ttab_pkg::NUM_VALS; f++)
                if (d[32*f +: 32] !== e.row[32*f +: 32]) begin
                    $display("%0t: field %0d expected %h actual %h", $time, f,
                             e.row[32*f +: 32], d[32*f +: 32]);
                    errors++;
                end
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk, aresetn;
    logic                          s_tvalid, s_tready, m_tvalid, m_tready;
    logic [ttab_pkg::ROW_W-1:0]    s_tdata, m_tdata;
    logic [ttab_pkg::CMD_W-1:0]    s_tuser;
    logic [ttab_pkg::STATUS_W-1:0] m_tuser;

    lookup_board board;
    int send_idle, recv_idle;
    int sent;

    trajectory_table_interpolator dut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_word(ttab_pkg::cmd_t'(s_tuser), s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser);
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    task automatic send_word(ttab_pkg::cmd_t cmd, logic signed [31:0] t, logic [191:0] v);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = {v, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 0;
        sent++;
    endtask

    function automatic logic [191:0] rand_vals();
        logic [191:0] v;
        for (int j = 0; j < ttab_pkg::NUM_VALS; j++) begin
            case ($urandom_range(3))
                0: v[32*j +: 32] = 32'h8000_0000 + $urandom_range(3);
                1: v[32*j +: 32] = 32'h7fff_ffff - $urandom_range(3);
                default: v[32*j +: 32] = $urandom;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [31:0] rand_time();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return $signed($urandom_range(4000)) - 2000;
        endcase
    endfunction

    task automatic drain();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic run_random(int n);
        int kind, nrows;
        logic signed [31:0] t;
        while (n > 0) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                // ordered table, then queries across and beyond it
                send_word(ttab_pkg::CMD_CLEAR, $urandom, 192'($urandom));
                nrows = ($urandom_range(15) == 0) ? $urandom_range(250, 260)
                                                  : $urandom_range(1, 8);
                t = $signed($urandom_range(2000)) - 1000;
                for (int r = 0; r < nrows; r++) begin
                    send_word(ttab_pkg::CMD_APPEND, t, rand_vals());
                    t += $urandom_range(($urandom_range(3) == 0) ? 0 : 1, 300);
                end
                for (int q = 0; q < 6; q++)
                    send_word(ttab_pkg::CMD_QUERY, rand_time(), rand_vals());
                n -= nrows + 7;
            end else if (kind < 8) begin
                send_word(ttab_pkg::CMD_APPEND, rand_time(), rand_vals());
                n--;
            end else if (kind == 8) begin
                send_word(ttab_pkg::CMD_QUERY, rand_time(), rand_vals());
                n--;
            end else begin
                send_word(($urandom_range(1) == 0) ? ttab_pkg::CMD_CLEAR : ttab_pkg::CMD_NONE,
                          $urandom, rand_vals());
                n--;
            end
        end
    endtask

    initial begin
        board = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = ttab_pkg::CMD_NONE;
        m_tready = 0;
        send_idle = 0;
        recv_idle = 0;
        sent = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        send_word(ttab_pkg::CMD_QUERY, 32'h7fff_ffff, '0);
        send_word(ttab_pkg::CMD_NONE, 5, '1);
        send_word(ttab_pkg::CMD_APPEND, 100, {6{32'h7fff_ffff}});
        send_word(ttab_pkg::CMD_APPEND, 200, {6{32'h8000_0000}});
        send_word(ttab_pkg::CMD_APPEND, 200, {6{32'h1234_5678}});
        send_word(ttab_pkg::CMD_APPEND, 50, '1);
        send_word(ttab_pkg::CMD_QUERY, 32'h8000_0000, '0);
        send_word(ttab_pkg::CMD_QUERY, 100, '0);
        send_word(ttab_pkg::CMD_QUERY, 150, '0);
        send_word(ttab_pkg::CMD_QUERY, 199, '0);
        send_word(ttab_pkg::CMD_QUERY, 50, '0);
        send_word(ttab_pkg::CMD_QUERY, 75, '0);
        send_word(ttab_pkg::CMD_CLEAR, 0, '0);
        send_word(ttab_pkg::CMD_QUERY, 7, '0);
        send_word(ttab_pkg::CMD_APPEND, 32'h8000_0000, {6{32'h8000_0000}});
        send_word(ttab_pkg::CMD_APPEND, 32'h7fff_ffff, {6{32'h7fff_ffff}});
        send_word(ttab_pkg::CMD_QUERY, 0, '0);
        send_word(ttab_pkg::CMD_QUERY, 32'h7fff_fffe, '0);
        drain();

        send_idle = 10;
        recv_idle = 88;
        run_random(500);
        drain();
        send_idle = 88;
        recv_idle = 10;
        run_random(500);
        send_idle = 0;
        recv_idle = 0;
        run_random(530);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
